// ----- rtl/rph_pkg.sv -----
// Shared types and constants of the radial profile histogram.
// Used by the channel interfaces, the bin calculator and the top level.
package rph_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BINS      = 2'd1;

  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int CNT_W = 32;
  localparam int SUM_W = 48;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic       start;
    logic [9:0] coord_x;
    logic [9:0] coord_y;
    logic [9:0] coord_z;
    logic [9:0] rad;
    logic [8:0] n1;
  } rph_calc_req_t;

  typedef struct packed {
    logic       done;
    logic       hit;
    logic [8:0] bin;
  } rph_calc_rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [SUM_W-1:0] sum;
  } rph_entry_t;

endpackage

// ----- rtl/rph_if.sv -----
// Valid/ready channel interfaces of the radial profile histogram.
// Depends on rph_pkg for the configuration field widths.
interface rph_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [9:0]        coord_x;
  logic [9:0]        coord_y;
  logic [9:0]        coord_z;
  logic signed [15:0] sample_value;
  logic [7:0]        bin_select;
  modport source (output valid, operation, coord_x, coord_y, coord_z, sample_value,
                  bin_select, input ready);
  modport sink (input valid, operation, coord_x, coord_y, coord_z, sample_value,
                bin_select, output ready);
endinterface

interface rph_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bin_number;
  logic        in_range;
  logic [31:0] hit_count;
  logic [47:0] mass_sum;
  modport source (output valid, bin_number, in_range, hit_count, mass_sum, input ready);
  modport sink (input valid, bin_number, in_range, hit_count, mass_sum, output ready);
endinterface

interface rph_cfg_if import rph_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;
  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

// ----- rtl/radial_profile_histogram_top.sv -----
// Top level of the radial profile histogram: control sequencer and bin memory.
// Depends on rph_pkg, the rph_if channel interfaces, rph_calc and rph_ram.
//
// Requests arrive on in_ch (valid/ready). Operation 0 bins a grid point by
// its distance from the grid center and adds one hit and the squared sample
// to that bin; operation 1 reads a bin; operation 2 clears a bin. Every
// request gives exactly one result on out_ch, in request order.
// cfg_ch writes the grid size (index 0) and the number of bins (index 1);
// it is always ready. The user must see that it is written only while no
// request is in flight; the block itself does not enforce this. One request
// is processed at a time. A point off the center and inside the radius
// passes the 20-step square root and the 21-step divide of rph_calc and the
// read-modify-write of the bin memory before it reaches the output register;
// points outside the radius or at the center skip the root and the divide.
// The next request can be taken in the cycle after the result is registered.
// After reset a clearing pass writes zero to all MAX_BINS memory entries,
// one per cycle; in_ch.ready stays low until the pass is done.
// A result waits in the output register while the receiver stalls; the
// next request is already taken and worked on meanwhile, and its result is
// held back until the output register is free.
module radial_profile_histogram_top import rph_pkg::*; #(
  parameter int MAX_BINS = 256,
  parameter int MAX_GRID = 1024
) (
  input logic      clk,
  input logic      rst_n,
  rph_in_if.sink   in_ch,
  rph_out_if.source out_ch,
  rph_cfg_if.sink  cfg_ch
);
  localparam int ABW = $clog2(MAX_BINS);

  localparam logic [2:0] T_CLR  = 3'd0;
  localparam logic [2:0] T_IDLE = 3'd1;
  localparam logic [2:0] T_CALC = 3'd2;
  localparam logic [2:0] T_RMW  = 3'd3;
  localparam logic [2:0] T_OUT  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [ABW-1:0] clr_addr_r;
  logic [10:0]    grid_r;
  logic [8:0]     bins_r;

  logic [10:0] grid_eff;
  logic [9:0]  rad;
  logic [8:0]  nb_eff;
  logic        accept;
  logic        sel_ok;

  logic [15:0]    mag_r;
  logic [31:0]    sq_r;
  logic [ABW-1:0] addr_r;
  logic           acc_r;
  logic [7:0]     res_bin_r;
  logic           res_ok_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic [SUM_W-1:0] res_sum_r;

  logic       out_valid_r;
  logic [7:0] out_bin_r;
  logic       out_ok_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic [SUM_W-1:0] out_sum_r;

  rph_calc_req_t calc_req;
  rph_calc_rsp_t calc_rsp;

  logic           ram_we, ram_re;
  logic [ABW-1:0] ram_waddr, ram_raddr;
  rph_entry_t     ram_wdata, ram_rdata;

  logic [CNT_W-1:0] cnt_new;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_new;
  logic             out_free;

  assign grid_eff = (32'(grid_r) > MAX_GRID) ? 11'(MAX_GRID) : grid_r;
  assign rad      = grid_eff[10:1];
  assign nb_eff   = (bins_r < 9'd2) ? 9'd2 :
                    ((32'(bins_r) > MAX_BINS) ? 9'(MAX_BINS) : bins_r);
  assign sel_ok   = {1'b0, in_ch.bin_select} < nb_eff;

  assign in_ch.ready  = (state_r == T_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  always_comb begin
    calc_req.start   = accept && (in_ch.operation == OP_ACCUM);
    calc_req.coord_x = in_ch.coord_x;
    calc_req.coord_y = in_ch.coord_y;
    calc_req.coord_z = in_ch.coord_z;
    calc_req.rad     = rad;
    calc_req.n1      = nb_eff - 9'd1;
  end

  rph_calc u_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (calc_req),
    .rsp   (calc_rsp)
  );

  assign cnt_new  = (ram_rdata.cnt == CNT_MAX) ? CNT_MAX : ram_rdata.cnt + 32'd1;
  assign sum_wide = {1'b0, ram_rdata.sum} + (SUM_W + 1)'(sq_r);
  assign sum_new  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '{cnt: '0, sum: '0};
    ram_re    = 1'b0;
    ram_raddr = ABW'(in_ch.bin_select);
    if (state_r == T_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
    end else if (accept && in_ch.operation == OP_CLEAR && sel_ok) begin
      ram_we    = 1'b1;
      ram_waddr = ABW'(in_ch.bin_select);
    end else if (state_r == T_RMW && acc_r) begin
      ram_we    = 1'b1;
      ram_wdata = '{cnt: cnt_new, sum: sum_new};
    end
    if (accept && in_ch.operation == OP_READ && sel_ok) begin
      ram_re = 1'b1;
    end else if (state_r == T_CALC && calc_rsp.done && calc_rsp.hit) begin
      ram_re    = 1'b1;
      ram_raddr = ABW'(calc_rsp.bin);
    end
  end

  rph_ram #(
    .WIDTH (CNT_W + SUM_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_CLR:  if (clr_addr_r == ABW'(MAX_BINS - 1)) state_nxt = T_IDLE;
      T_IDLE: begin
        if (accept) begin
          if (in_ch.operation == OP_ACCUM) begin
            state_nxt = T_CALC;
          end else if (in_ch.operation == OP_READ && sel_ok) begin
            state_nxt = T_RMW;
          end else begin
            state_nxt = T_OUT;
          end
        end
      end
      T_CALC: begin
        if (calc_rsp.done) state_nxt = calc_rsp.hit ? T_RMW : T_OUT;
      end
      T_RMW:   state_nxt = T_OUT;
      T_OUT:   if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_CLR;
      clr_addr_r  <= '0;
      grid_r      <= 11'd256;
      bins_r      <= 9'd64;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == T_CLR) begin
        clr_addr_r <= clr_addr_r + ABW'(1);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.reg_index == REG_GRID_SIZE) begin
          grid_r <= cfg_ch.reg_data[10:0];
        end else if (cfg_ch.reg_index == REG_BINS) begin
          bins_r <= cfg_ch.reg_data[8:0];
        end
      end
      if (state_r == T_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= mag_r * mag_r;
    if (accept) begin
      mag_r     <= in_ch.sample_value[15] ? 16'(-in_ch.sample_value) : in_ch.sample_value;
      addr_r    <= ABW'(in_ch.bin_select);
      acc_r     <= 1'b0;
      res_cnt_r <= '0;
      res_sum_r <= '0;
      if (in_ch.operation == OP_READ || in_ch.operation == OP_CLEAR) begin
        res_bin_r <= in_ch.bin_select;
        res_ok_r  <= sel_ok;
      end else begin
        res_bin_r <= '0;
        res_ok_r  <= 1'b0;
      end
    end
    if (state_r == T_CALC && calc_rsp.done) begin
      addr_r    <= ABW'(calc_rsp.bin);
      acc_r     <= calc_rsp.hit;
      res_ok_r  <= calc_rsp.hit;
      res_bin_r <= calc_rsp.hit ? 8'(calc_rsp.bin) : 8'd0;
    end
    if (state_r == T_RMW) begin
      if (acc_r) begin
        res_cnt_r <= cnt_new;
        res_sum_r <= sum_new;
      end else begin
        res_cnt_r <= ram_rdata.cnt;
        res_sum_r <= ram_rdata.sum;
      end
    end
    if (state_r == T_OUT && out_free) begin
      out_bin_r <= res_bin_r;
      out_ok_r  <= res_ok_r;
      out_cnt_r <= res_cnt_r;
      out_sum_r <= res_sum_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.bin_number = out_bin_r;
  assign out_ch.in_range   = out_ok_r;
  assign out_ch.hit_count  = out_cnt_r;
  assign out_ch.mass_sum   = out_sum_r;
endmodule

// ----- rtl/rph_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/rph_calc.sv -----
// Bin calculator: squared distance, iterative square root and iterative divide.
// Depends on rph_pkg for the request and response structs.
module rph_calc import rph_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  rph_calc_req_t req,
  output rph_calc_rsp_t rsp
);
  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_SQ   = 3'd1;
  localparam logic [2:0] C_D2   = 3'd2;
  localparam logic [2:0] C_CMP  = 3'd3;
  localparam logic [2:0] C_SQRT = 3'd4;
  localparam logic [2:0] C_DIV  = 3'd5;
  localparam logic [2:0] C_DONE = 3'd6;
  localparam logic [2:0] C_BIN  = 3'd7;
  localparam logic [4:0] STEPS  = 5'd20;

  logic [2:0]  state_r, state_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [9:0]  dx_r, dy_r, dz_r, rad_r;
  logic [8:0]  n1_r;
  logic [19:0] sqx_r, sqy_r, sqz_r, radsq_r;
  logic [17:0] n1sq_r;
  logic [21:0] d2_r;
  logic [39:0] prod_r;
  logic [21:0] rem_r;
  logic [19:0] root_r;
  logic [19:0] quo_r;
  logic [10:0] drem_r;
  logic        hit_r;
  logic [8:0]  bin_r;

  logic [21:0] rem_sh, trial;
  logic [10:0] drem_sh;
  logic [9:0]  den;

  function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  assign rem_sh  = {rem_r[19:0], prod_r[39:38]};
  assign trial   = {root_r, 2'b01};
  assign den     = rad_r - 10'd1;
  assign drem_sh = {drem_r[9:0], quo_r[19]};

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      C_IDLE: if (req.start) state_nxt = C_SQ;
      C_SQ:   state_nxt = C_D2;
      C_D2:   state_nxt = C_CMP;
      C_CMP: begin
        if (d2_r >= {2'b00, radsq_r} || d2_r <= 22'd1) begin
          state_nxt = C_DONE;
        end else begin
          state_nxt = C_SQRT;
          step_nxt  = '0;
        end
      end
      C_SQRT: begin
        step_nxt = step_r + 5'd1;
        if (step_r == STEPS - 5'd1) begin
          state_nxt = C_DIV;
          step_nxt  = '0;
        end
      end
      C_DIV: begin
        step_nxt = step_r + 5'd1;
        if (step_r == STEPS) state_nxt = C_BIN;
      end
      C_BIN:   state_nxt = C_DONE;
      C_DONE:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: begin
        dx_r  <= absdiff(req.coord_x, req.rad);
        dy_r  <= absdiff(req.coord_y, req.rad);
        dz_r  <= absdiff(req.coord_z, req.rad);
        rad_r <= req.rad;
        n1_r  <= req.n1;
      end
      C_SQ: begin
        sqx_r   <= dx_r * dx_r;
        sqy_r   <= dy_r * dy_r;
        sqz_r   <= dz_r * dz_r;
        radsq_r <= rad_r * rad_r;
        n1sq_r  <= n1_r * n1_r;
      end
      C_D2: d2_r <= 22'(sqx_r) + 22'(sqy_r) + 22'(sqz_r);
      C_CMP: begin
        prod_r <= 40'(d2_r) * 40'(n1sq_r);
        rem_r  <= '0;
        root_r <= '0;
        hit_r  <= d2_r < {2'b00, radsq_r};
        bin_r  <= '0;
      end
      C_SQRT: begin
        prod_r <= {prod_r[37:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[18:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[18:0], 1'b0};
        end
      end
      C_DIV: begin
        if (step_r == 5'd0) begin
          quo_r  <= root_r - 20'(n1_r);
          drem_r <= '0;
        end else if (drem_sh >= 11'(den)) begin
          drem_r <= drem_sh - 11'(den);
          quo_r  <= {quo_r[18:0], 1'b1};
        end else begin
          drem_r <= drem_sh;
          quo_r  <= {quo_r[18:0], 1'b0};
        end
      end
      C_BIN: bin_r <= (quo_r >= 20'(n1_r)) ? n1_r : 9'(quo_r + 20'd1);
      C_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == C_DONE);
    rsp.hit  = hit_r;
    rsp.bin  = bin_r;
  end
endmodule
